/* hdl/skf_pkg.sv */
// Scalar Kalman filter constants: config register map, commands, noise reset values.
`timescale 1ns / 1ps
`default_nettype none
package skf_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_ESTIMATE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_VARIANCE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd3;

    localparam logic CMD_FILTER  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam longint PROCESS_NOISE_RESET     = 655;
    localparam longint MEASUREMENT_NOISE_RESET = 65536;

endpackage
`default_nettype wire

/* hdl/scalar_kalman_filter.sv */
// Scalar Kalman filter: one predict/update step per filter command on a shared serial unit.
// Input channel (i_valid/o_ready) carries i_cmd and i_measurement. A filter command
// runs one predict/update step; a restart command loads the estimate and variance
// from the init registers and reports a gain of zero. Output channel
// (o_valid/i_ready) returns estimate, variance and gain, one result per item.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write registers only while the block is idle.
// A restart passes from accept through the final state into the output register.
// A filter step skips the divider when the measurement noise is zero. The cost
// is set by the restoring divider (one quotient bit per cycle) and two shift-add
// multiplies (one multiplier bit per cycle), all run in turn. One item is in
// work at a time; o_ready is high only while idle. The result sits in an output
// register, so a new item can be accepted while the previous result waits; a
// step that ends while the receiver still stalls holds in its final state until
// the output register frees.
// Reset clears the estimate and variance to zero, loads the register defaults
// and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module scalar_kalman_filter #(
    parameter int DATA_WIDTH     = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [skf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]               i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_cmd,
    input  wire logic signed [DATA_WIDTH-1:0]        i_measurement,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]             o_estimate,
    output logic [DATA_WIDTH-1:0]                    o_variance,
    output logic [GAIN_FRAC_BITS:0]                  o_gain
);

    localparam int DW  = DATA_WIDTH;
    localparam int GF  = GAIN_FRAC_BITS;
    localparam int GW  = GF + 1;
    localparam int MAW = DW + 1;
    localparam int PW  = MAW + GW;
    localparam int EW  = DW + 4;
    localparam int CW  = $clog2(GW + 1);

    localparam logic [GW-1:0] GONE = {1'b1, {GF{1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRIOR, ST_GSET, ST_DIV, ST_VSET, ST_MUL,
        ST_ESET, ST_DLT, ST_EST, ST_OUT
    } t_state;

    t_state                   r_state;
    logic                     r_phase;
    logic [CW-1:0]            r_cnt;
    logic signed [DW-1:0]     r_init_est;
    logic [DW-1:0]            r_init_var;
    logic [DW-1:0]            r_q;
    logic [DW-1:0]            r_r;
    logic signed [DW-1:0]     r_est;
    logic [DW-1:0]            r_var;
    logic signed [DW-1:0]     r_meas;
    logic [DW-1:0]            r_prior;
    logic [MAW-1:0]           r_den;
    logic [MAW-1:0]           r_rem;
    logic [GW-1:0]            r_gain;
    logic [MAW-1:0]           r_ma;
    logic [PW-1:0]            r_acc;
    logic                     r_neg;
    logic signed [DW+2:0]     r_delta;
    logic                     r_o_valid;
    logic signed [DW-1:0]     r_o_est;
    logic [DW-1:0]            r_o_var;
    logic [GW-1:0]            r_o_gain;

    logic [DW:0]              prior_sum;
    logic [DW-1:0]            prior_sat;
    logic [MAW-1:0]           den_sum;
    logic [MAW:0]             div_shift;
    logic                     div_take;
    logic [MAW:0]             div_diff;
    logic [MAW:0]             mul_sum;
    logic signed [DW+1:0]     diff;
    logic [MAW-1:0]           diff_mag;
    logic [PW:0]              prod_signed;
    logic signed [EW-1:0]     nest;
    logic                     nest_ovf;
    logic signed [DW-1:0]     nest_sat;
    logic                     out_free;

    assign prior_sum = {1'b0, r_var} + {1'b0, r_q};
    assign prior_sat = prior_sum[DW] ? {DW{1'b1}} : prior_sum[DW-1:0];
    assign den_sum   = {1'b0, r_prior} + {1'b0, r_r};

    assign div_shift = {r_rem, 1'b0};
    assign div_diff  = div_shift - {1'b0, r_den};
    assign div_take  = div_shift >= {1'b0, r_den};

    assign mul_sum = {1'b0, r_acc[PW-1:GW]} + {1'b0, (r_acc[0] ? r_ma : {MAW{1'b0}})};

    assign diff     = {{2{r_meas[DW-1]}}, r_meas} - {{2{r_est[DW-1]}}, r_est};
    assign diff_mag = diff[DW+1] ? MAW'(-diff) : MAW'(diff);

    assign prod_signed = r_neg ? -{1'b0, r_acc} : {1'b0, r_acc};

    assign nest     = {{4{r_est[DW-1]}}, r_est} + {r_delta[DW+2], r_delta};
    assign nest_ovf = (nest[EW-1:DW-1] != {(EW-DW+1){nest[EW-1]}});
    assign nest_sat = nest_ovf ? (nest[EW-1] ? {1'b1, {(DW-1){1'b0}}}
                                             : {1'b0, {(DW-1){1'b1}}})
                               : nest[DW-1:0];

    assign out_free = !r_o_valid || i_ready;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_estimate  = r_o_est;
    assign o_variance  = r_o_var;
    assign o_gain      = r_o_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_o_valid  <= 1'b0;
            r_init_est <= '0;
            r_init_var <= '0;
            r_q        <= DW'(skf_pkg::PROCESS_NOISE_RESET);
            r_r        <= DW'(skf_pkg::MEASUREMENT_NOISE_RESET);
            r_est      <= '0;
            r_var      <= '0;
        end else begin
            if (r_o_valid && i_ready && r_state != ST_OUT) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    skf_pkg::CFG_INIT_ESTIMATE:     r_init_est <= i_cfg_data;
                    skf_pkg::CFG_INIT_VARIANCE:     r_init_var <= i_cfg_data;
                    skf_pkg::CFG_PROCESS_NOISE:     r_q        <= i_cfg_data;
                    skf_pkg::CFG_MEASUREMENT_NOISE: r_r        <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_meas <= i_measurement;
                        if (i_cmd == skf_pkg::CMD_RESTART) begin
                            r_est   <= r_init_est;
                            r_var   <= r_init_var;
                            r_gain  <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_PRIOR;
                        end
                    end
                end
                ST_PRIOR: begin
                    r_prior <= prior_sat;
                    r_state <= ST_GSET;
                end
                ST_GSET: begin
                    r_den <= den_sum;
                    r_rem <= {1'b0, r_prior};
                    r_cnt <= '0;
                    if (den_sum == '0) begin
                        r_gain  <= '0;
                        r_state <= ST_VSET;
                    end else if (r_r == '0) begin
                        r_gain  <= GONE;
                        r_state <= ST_VSET;
                    end else begin
                        r_gain  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= div_take ? div_diff[MAW-1:0] : div_shift[MAW-1:0];
                    r_gain <= {r_gain[GW-2:0], div_take};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(GF - 1)) begin
                        r_state <= ST_VSET;
                    end
                end
                ST_VSET: begin
                    r_ma    <= {1'b0, r_prior};
                    r_acc   <= {{MAW{1'b0}}, GONE - r_gain};
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_acc <= {mul_sum, r_acc[GW-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(GF)) begin
                        r_state <= r_phase ? ST_DLT : ST_ESET;
                    end
                end
                ST_ESET: begin
                    r_var   <= r_acc[GF +: DW];
                    r_ma    <= diff_mag;
                    r_neg   <= diff[DW+1];
                    r_acc   <= {{MAW{1'b0}}, r_gain};
                    r_cnt   <= '0;
                    r_phase <= 1'b1;
                    r_state <= ST_MUL;
                end
                ST_DLT: begin
                    r_delta <= prod_signed[PW:GF];
                    r_state <= ST_EST;
                end
                ST_EST: begin
                    r_est   <= nest_sat;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_est   <= r_est;
                        r_o_var   <= r_var;
                        r_o_gain  <= r_gain;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
